[rtl/srti_pkg.sv]
// Shared types and constants for the sorted region table.
package srti_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } region_t;

  typedef struct packed {
    logic shift;
    logic occupied;
  } cell_ctrl_t;

  typedef struct packed {
    logic less;
    logic eq;
  } cell_flags_t;

endpackage

[rtl/srti_req_if.sv]
// Request channel: one region to insert per beat.
interface srti_req_if;
  import srti_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] region_length;

  modport source (output valid, output region_start, output region_length, input ready);
  modport sink   (input valid, input region_start, input region_length, output ready);
endinterface

[rtl/srti_rsp_if.sv]
// Response channel: status, slot and count per beat.
interface srti_rsp_if;
  import srti_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   entry_count;

  modport source (output valid, output status, output slot, output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input entry_count, output ready);
endinterface

[rtl/srti_cell.sv]
// One table cell: holds a region key, compares it and shifts on insert.
module srti_cell
  import srti_pkg::*;
(
  input  logic        clk_i,
  input  region_t     key_i,
  input  region_t     prev_key_i,
  input  logic        prev_less_i,
  input  cell_ctrl_t  ctrl_i,
  output region_t     key_o,
  output cell_flags_t flags_o
);

  region_t key_q, key_d;
  logic    less_w;

  assign less_w = (key_q.start < key_i.start) ||
                  ((key_q.start == key_i.start) && (key_q.length < key_i.length));

  assign flags_o.less = ctrl_i.occupied && less_w;
  assign flags_o.eq   = ctrl_i.occupied && (key_q == key_i);

  // Keep when smaller; take the new key at the boundary, else take the neighbor.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.shift && !flags_o.less) begin
      key_d = prev_less_i ? key_i : prev_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

[rtl/sorted_region_table_insert_core.sv]
// Sorted region table top level: request staging, cell row and response register.
// A request beat is staged in req_q; its result is then registered for the response beat.
// Throughput: one request per cycle while the response does not stall; all cells compare and shift together.
// A new request is taken while a response waits, as long as the staged one can move.
// Reset clears the entry count and the handshake state; cell contents stay undefined
// and are never read until written.
module sorted_region_table_insert_core
  import srti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  srti_req_if.sink   req_i,
  srti_rsp_if.source rsp_o
);

  region_t                 req_q;
  logic                    busy_q, busy_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [SLOT_W-1:0]       cnt_out_q, cnt_out_d;
  logic [CNT_W-1:0]        count_q, count_d;

  logic                    out_free, fire, accept;
  logic                    dup, full, insert;
  logic [CNT_W-1:0]        pos;
  logic [TABLE_DEPTH-1:0]  less_w, eq_w, prev_less_w;
  region_t                 keys_w [TABLE_DEPTH];

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign fire        = busy_q && out_free;
  assign req_i.ready = !busy_q || fire;
  assign accept      = req_i.valid && req_i.ready;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctrl_t  ctrl;
    cell_flags_t flags;
    region_t     prev_key;

    if (i == 0) begin : g_head
      assign prev_less_w[i] = 1'b1;
      assign prev_key       = req_q;
    end else begin : g_body
      assign prev_less_w[i] = less_w[i-1];
      assign prev_key       = keys_w[i-1];
    end

    assign ctrl.shift    = insert;
    assign ctrl.occupied = (count_q > CNT_W'(i));

    srti_cell u_cell (
      .clk_i      (clk_i),
      .key_i      (req_q),
      .prev_key_i (prev_key),
      .prev_less_i(prev_less_w[i]),
      .ctrl_i     (ctrl),
      .key_o      (keys_w[i]),
      .flags_o    (flags)
    );

    assign less_w[i] = flags.less;
    assign eq_w[i]   = flags.eq;
  end

  assign dup    = |eq_w;
  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign insert = fire && !dup && !full;

  // The less flags form a prefix; the slot is where that prefix ends.
  always_comb begin
    pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!less_w[i] && prev_less_w[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
    if (less_w[TABLE_DEPTH-1]) begin
      pos = CNT_W'(TABLE_DEPTH);
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    cnt_out_d   = cnt_out_q;
    count_d     = insert ? count_q + CNT_W'(1) : count_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      status_d    = dup ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
      slot_d      = SLOT_W'(pos);
      cnt_out_d   = SLOT_W'(count_d);
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    slot_q    <= slot_d;
    cnt_out_q <= cnt_out_d;
    if (accept) begin
      req_q.start  <= req_i.region_start;
      req_q.length <= req_i.region_length;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.slot        = slot_q;
  assign rsp_o.entry_count = cnt_out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count by one");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !insert) |=> (count_q == $past(count_q)))
    else $error("rejected request changed the count");

  a_busy_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request left no response");
`endif

endmodule
